// ===== rtl/wpk_pkg.sv =====
package wpk_pkg;

    localparam int VAL_W = 32;
    localparam int RUN_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic rd;
        logic bwd_upd;
        logic fwd_eval;
        logic idx_inc;
        logic srch_step;
        logic repl;
        logic res_direct;
        logic div_start;
        logic res_div;
        logic emit_shift;
        logic run_clr;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic idx_zero;
        logic idx_last;
        logic peak_ok;
        logic srch_last;
        logic conv_direct;
        logic div_done;
        logic emit_last;
    } sts_t;

endpackage

// ===== rtl/wpk_div.sv =====
module wpk_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] numer,
    input  logic [31:0] denom,
    output logic        done,
    output logic [31:0] quot
);
    import wpk_pkg::*;

    localparam int DD_W = VAL_W + 16;
    localparam int CNT_W = $clog2(DD_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DD_W-1:0]  dd_reg;
    logic [VAL_W:0]   rem_reg;
    logic [VAL_W-1:0] dsr_reg;
    logic [VAL_W:0]   shifted;
    logic             qbit;

    always_comb
    begin
        shifted = {rem_reg[VAL_W-1:0], dd_reg[DD_W-1]};
        qbit = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DD_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dd_reg  <= {numer, 16'h0000};
            rem_reg <= '0;
            dsr_reg <= denom;
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? (shifted - {1'b0, dsr_reg}) : shifted;
            dd_reg  <= {dd_reg[DD_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = (|dd_reg[DD_W-1:VAL_W]) ? '1 : dd_reg[VAL_W-1:0];

endmodule

// ===== rtl/wpk_dpath.sv =====
module wpk_dpath #(
    parameter int MAX_SAMPLES = 4096,
    parameter int KEEP = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  wpk_pkg::cmd_t                  cmd,
    output wpk_pkg::sts_t                  sts,
    input  logic [31:0]                    sample_position,
    input  logic signed [31:0]             sample_value,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wpk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic [31:0]                    peak_result,
    output logic                           last_result,
    output logic                           overflow_flag
);
    import wpk_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int DW = (CNT_W > RUN_W) ? CNT_W : RUN_W;
    localparam int KW = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int PW = VAL_W + 17;

    logic [VAL_W-1:0]        pos_mem  [MAX_SAMPLES];
    logic signed [VAL_W-1:0] val_mem  [MAX_SAMPLES];
    logic [RUN_W-1:0]        rlen_mem [MAX_SAMPLES];

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [VAL_W-1:0] runmax_reg;
    logic                    ovf_reg;
    logic [15:0]             thr_reg;
    logic [7:0]              win_reg;
    logic [VAL_W-1:0]        conv_reg;
    logic [KW-1:0]           ecnt_reg;

    logic signed [PW-1:0]    rhs_reg;
    logic [AW-1:0]           idx_reg;
    logic signed [VAL_W-1:0] prev_reg;
    logic [RUN_W-1:0]        run_reg;
    logic [VAL_W-1:0]        rd_pos_reg;
    logic signed [VAL_W-1:0] rd_val_reg;
    logic [RUN_W-1:0]        rd_rlen_reg;
    logic [VAL_W-1:0]        kp_reg [KEEP];
    logic signed [VAL_W-1:0] kv_reg [KEEP];
    logic [VAL_W-1:0]        cand_pos_reg;
    logic signed [VAL_W-1:0] cand_val_reg;
    logic [KW-1:0]           sidx_reg;
    logic [KW-1:0]           slot_reg;
    logic signed [VAL_W-1:0] small_reg;
    logic signed [VAL_W-1:0] slotval_reg;
    logic [VAL_W-1:0]        res_reg;
    logic                    last_reg;

    logic                    full;
    logic [7:0]              w_eff;
    logic [DW-1:0]           idx_ext;
    logic [DW-1:0]           last_ext;
    logic [DW-1:0]           w_ext;
    logic [DW-1:0]           left;
    logic [DW-1:0]           right;
    logic [RUN_W-1:0]        run_inc;
    logic [RUN_W-1:0]        run_new;
    logic                    step_ok;
    logic signed [PW-1:0]    lhs;
    logic signed [VAL_W-1:0] search_val;
    logic                    div_done;
    logic [VAL_W-1:0]        div_q;

    always_comb
    begin
        full = (cnt_reg == CNT_W'(MAX_SAMPLES));
        w_eff = (win_reg == 8'd0) ? 8'd1 : win_reg;
        idx_ext = DW'(idx_reg);
        last_ext = DW'(cnt_reg - 1'b1);
        w_ext = DW'(w_eff);
        left = (idx_ext < w_ext) ? idx_ext : w_ext;
        right = ((last_ext - idx_ext) < w_ext) ? (last_ext - idx_ext) : w_ext;
        run_inc = (run_reg == '1) ? run_reg : run_reg + 1'b1;
        step_ok = (rd_val_reg >= prev_reg);
        if (cmd.bwd_upd)
            run_new = (idx_ext == last_ext || !step_ok) ? '0 : run_inc;
        else
            run_new = (idx_reg == '0 || !step_ok) ? '0 : run_inc;
        lhs = PW'({{5{rd_val_reg[VAL_W-1]}}, rd_val_reg, 12'h000});
        search_val = kv_reg[sidx_reg];
        sts.cnt_zero = (cnt_reg == '0);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_last = (idx_ext == last_ext);
        sts.peak_ok = (lhs >= rhs_reg) && (DW'(run_new) >= left)
                      && (DW'(rd_rlen_reg) >= right);
        sts.srch_last = (sidx_reg == KW'(KEEP - 1));
        sts.conv_direct = (conv_reg == '0) || (kp_reg[KEEP-1] == '0);
        sts.div_done = div_done;
        sts.emit_last = (ecnt_reg == KW'(KEEP - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            runmax_reg <= '0;
            ovf_reg    <= 1'b0;
            thr_reg    <= '0;
            win_reg    <= 8'd1;
            conv_reg   <= '0;
            ecnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:  thr_reg <= cfg_data[15:0];
                    CFG_WINDOW:     win_reg <= cfg_data[7:0];
                    CFG_CONVERSION: conv_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.load)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (runmax_reg < sample_value)
                        runmax_reg <= sample_value;
                end
            end
            if (cmd.scan_init)
                ecnt_reg <= '0;
            if (cmd.emit_shift)
                ecnt_reg <= ecnt_reg + 1'b1;
            if (cmd.run_clr)
            begin
                cnt_reg    <= '0;
                runmax_reg <= '0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            pos_mem[cnt_reg[AW-1:0]] <= sample_position;
            val_mem[cnt_reg[AW-1:0]] <= sample_value;
        end
        if (cmd.bwd_upd)
            rlen_mem[idx_reg] <= run_new;
        if (cmd.rd)
        begin
            rd_pos_reg  <= pos_mem[idx_reg];
            rd_val_reg  <= val_mem[idx_reg];
            rd_rlen_reg <= rlen_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            rhs_reg <= $signed({{(PW-17){1'b0}}, 1'b0, thr_reg})
                       * $signed({{(PW-VAL_W){runmax_reg[VAL_W-1]}}, runmax_reg});
            idx_reg <= AW'(cnt_reg - 1'b1);
            for (int i = 0; i < KEEP; i++)
            begin
                kp_reg[i] <= '0;
                kv_reg[i] <= '0;
            end
        end
        if (cmd.bwd_upd)
        begin
            prev_reg <= rd_val_reg;
            run_reg  <= run_new;
            if (idx_reg != '0)
                idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.fwd_eval)
        begin
            prev_reg     <= rd_val_reg;
            run_reg      <= run_new;
            cand_pos_reg <= rd_pos_reg;
            cand_val_reg <= rd_val_reg;
            sidx_reg     <= '0;
            slot_reg     <= '0;
            small_reg    <= runmax_reg;
            slotval_reg  <= kv_reg[0];
        end
        if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.srch_step)
        begin
            if (small_reg >= search_val)
            begin
                slot_reg    <= sidx_reg;
                small_reg   <= search_val;
                slotval_reg <= search_val;
            end
            sidx_reg <= sidx_reg + 1'b1;
        end
        if (cmd.repl && (slotval_reg < cand_val_reg))
        begin
            for (int i = 0; i < KEEP - 1; i++)
            begin
                if (KW'(i) >= slot_reg)
                begin
                    kp_reg[i] <= kp_reg[i+1];
                    kv_reg[i] <= kv_reg[i+1];
                end
            end
            kp_reg[KEEP-1] <= cand_pos_reg;
            kv_reg[KEEP-1] <= cand_val_reg;
        end
        if (cmd.emit_shift)
        begin
            for (int i = KEEP - 1; i > 0; i--)
                kp_reg[i] <= kp_reg[i-1];
        end
        if (cmd.res_direct)
        begin
            res_reg  <= (conv_reg == '0) ? kp_reg[KEEP-1] : '0;
            last_reg <= sts.emit_last;
        end
        if (cmd.res_div)
        begin
            res_reg  <= div_q;
            last_reg <= sts.emit_last;
        end
    end

    wpk_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (conv_reg),
        .denom (kp_reg[KEEP-1]),
        .done  (div_done),
        .quot  (div_q)
    );

    assign peak_result = res_reg;
    assign last_result = last_reg;
    assign overflow_flag = ovf_reg;

endmodule

// ===== rtl/wpk_ctrl.sv =====
module wpk_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          opcode,
    input  wpk_pkg::sts_t sts,
    output wpk_pkg::cmd_t cmd,
    output logic          busy,
    output logic          result_valid
);
    import wpk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BRD,
        S_BUPD,
        S_FRD,
        S_FEVAL,
        S_SRCH,
        S_REPL,
        S_OSEL,
        S_ODIV,
        S_OOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next = sts.cnt_zero ? S_OSEL : S_BRD;
                    end
                end
            end
            S_BRD:
            begin
                cmd.rd = 1'b1;
                state_next = S_BUPD;
            end
            S_BUPD:
            begin
                cmd.bwd_upd = 1'b1;
                state_next = sts.idx_zero ? S_FRD : S_BRD;
            end
            S_FRD:
            begin
                cmd.rd = 1'b1;
                state_next = S_FEVAL;
            end
            S_FEVAL:
            begin
                cmd.fwd_eval = 1'b1;
                if (sts.peak_ok)
                    state_next = S_SRCH;
                else if (sts.idx_last)
                    state_next = S_OSEL;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (sts.srch_last)
                    state_next = S_REPL;
            end
            S_REPL:
            begin
                cmd.repl = 1'b1;
                if (sts.idx_last)
                    state_next = S_OSEL;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_OSEL:
            begin
                if (sts.conv_direct)
                begin
                    cmd.res_direct = 1'b1;
                    state_next = S_OOUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_ODIV;
                end
            end
            S_ODIV:
            begin
                if (sts.div_done)
                begin
                    cmd.res_div = 1'b1;
                    state_next = S_OOUT;
                end
            end
            S_OOUT:
            begin
                cmd.emit_shift = 1'b1;
                if (sts.emit_last)
                begin
                    cmd.run_clr = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_OSEL;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            valid_reg <= (state_next == S_OOUT);
        end
    end

    assign busy = busy_reg;
    assign result_valid = valid_reg;

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result transfer while not busy");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_FINISH) |=> busy)
        else $error("finish did not start a scan");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OOUT && sts.emit_last) |=> !busy)
        else $error("still busy after last result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> !busy)
        else $error("load left the block busy");

endmodule

// ===== rtl/windowed_peak_top_n_picker.sv =====
// Peak picker: a load item (opcode 0) is taken while idle and busy stays low,
// so loads can arrive every cycle while no scan runs. A finish item (opcode 1)
// raises busy for the scan: a backward slope pass and a forward pass over the
// stored samples (one sample memory port, one read then one update or evaluate
// per sample), plus a search of the KEEP slots and a replace for each sample
// that passes the peak test. Then KEEP results follow, one per result_valid
// pulse, newest kept first; converted ones go through the bit-serial divider,
// raw ones do not. The receiver cannot stall: take each result in the cycle it is shown.
module windowed_peak_top_n_picker #(
    parameter int MAX_SAMPLES = 4096,
    parameter int KEEP = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           opcode,
    input  logic [31:0]                    sample_position,
    input  logic signed [31:0]             sample_value,
    output logic                           result_valid,
    output logic [31:0]                    peak_result,
    output logic                           last_result,
    output logic                           overflow_flag,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wpk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import wpk_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    wpk_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    wpk_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .KEEP        (KEEP)
    ) u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .sample_position (sample_position),
        .sample_value    (sample_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .peak_result     (peak_result),
        .last_result     (last_result),
        .overflow_flag   (overflow_flag)
    );

endmodule
